// File: rtl/core/wopu_pkg.sv
`default_nettype none
package wopu_pkg;
   localparam int CORDIC_STEPS = 24;
   localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int STEP_W = $clog2(NSTEP + 1);
   localparam logic [31:0] DIST_RESET = 32'd1640752;
   localparam logic [31:0] TURN_RESET = 32'd290146;
   localparam logic [0:0] CSR_DIST = 1'b0;
   localparam logic [0:0] CSR_TURN = 1'b1;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic signed [47:0] travel;
      logic [31:0]        turn;
      // floor(turn / 2) taken from the full-width signed turn
      logic [31:0]        half;
   } job_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
         5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
         5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
         5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001; default: r = 32'h00000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/wopu_front.sv
`default_nettype none
module wopu_front import wopu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_wheel_select,
   input  wire logic signed [15:0] req_tick_delta,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data,
   output logic             job_valid,
   input  wire logic        job_take,
   output job_type          job
);
   // two-entry queue of multiplied jobs; a multiply stage feeds it
   logic [31:0] dist_ff, turn_ff;
   logic        mul_v_ff;
   logic        mul_r_ff;
   logic signed [15:0] mul_t_ff;
   job_type     q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ff, wr_ff;
   logic signed [47:0] p_w;
   logic signed [47:0] a_w;
   logic signed [47:0] as_w;
   logic        push;

   assign csr_ready = 1'b1;
   // hold input while the multiply stage is busy or the queue is full
   assign req_stall = mul_v_ff || (cnt_ff == 2'd2);
   assign p_w = 48'(mul_t_ff * $signed({1'b0, dist_ff}));
   assign a_w = 48'(mul_t_ff * $signed({1'b0, turn_ff}));
   assign as_w = mul_r_ff ? a_w : -a_w;
   assign push = mul_v_ff;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET; turn_ff <= TURN_RESET;
         mul_v_ff <= 1'b0; cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_DIST) dist_ff <= csr_data;
            else turn_ff <= csr_data;
         end
         mul_v_ff <= req_valid && !req_stall;
         if (push) wr_ff <= ~wr_ff;
         if (job_take && job_valid) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(job_take && job_valid);
      end
      if (req_valid && !req_stall) begin
         mul_t_ff <= req_tick_delta; mul_r_ff <= req_wheel_select;
      end
      if (push) begin
         q_ff[wr_ff].travel <= p_w;
         q_ff[wr_ff].turn <= as_w[31:0];
         q_ff[wr_ff].half <= as_w[32:1];
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue overfill");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      mul_v_ff |-> req_stall) else $error("accept during multiply");
endmodule
`default_nettype wire

// File: rtl/core/wopu_back.sv
`default_nettype none
module wopu_back import wopu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_take,
   input  wire job_type     job,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [47:0] rsp_x_pos,
   output logic signed [47:0] rsp_y_pos,
   output logic [31:0]      rsp_heading
);
   localparam logic [2:0] S_IDLE = 3'd0, S_ROT = 3'd1, S_MUL = 3'd2,
                          S_ADD = 3'd3, S_OUT = 3'd4;
   logic [2:0] st_ff;
   logic [STEP_W-1:0] i_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [1:0]  quad_ff;
   logic signed [47:0] p_ff;
   logic [31:0] turn_ff;
   logic signed [47:0] px_ff, py_ff;
   logic [31:0] ph_ff;
   logic [47:0] mp_ff;
   logic [31:0] mc_ff;
   logic        neg_ff, sel_ff;
   logic [55:0] hi_ff, lo_ff;
   logic signed [48:0] dx_ff;
   logic [1:0]  ph2_ff;
   logic signed [33:0] co_w, si_w, c_w, xs_w, ys_w;
   logic [31:0] mid_w, at_w;
   logic [47:0] q_w;
   logic signed [49:0] sum_w;
   logic signed [47:0] sat_w;

   assign mid_w = ph_ff + job.half;
   assign at_w = atan_turn(i_ff[4:0]);
   assign xs_w = x_ff >>> i_ff;
   assign ys_w = y_ff >>> i_ff;
   always_comb begin
      case (quad_ff)
         2'd0: begin co_w = x_ff; si_w = y_ff; end
         2'd1: begin co_w = -y_ff; si_w = x_ff; end
         2'd2: begin co_w = -x_ff; si_w = -y_ff; end
         default: begin co_w = y_ff; si_w = -x_ff; end
      endcase
   end
   assign c_w = sel_ff ? si_w : co_w;
   assign q_w = 48'((hi_ff + (lo_ff >> 24)) >> 15);
   assign sum_w = (sel_ff ? 50'(py_ff) : 50'(px_ff)) + 50'(dx_ff);
   assign sat_w = (sum_w > 50'(POS_MAX)) ? POS_MAX :
                  (sum_w < 50'(POS_MIN)) ? POS_MIN : sum_w[47:0];
   assign job_take = (st_ff == S_IDLE) && job_valid;
   assign rsp_valid = (st_ff == S_OUT);
   assign rsp_x_pos = px_ff;
   assign rsp_y_pos = py_ff;
   assign rsp_heading = ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; px_ff <= '0; py_ff <= '0; ph_ff <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (job_valid) begin
               quad_ff <= mid_w[31:30];
               z_ff <= 34'({2'b0, mid_w[29:0]});
               x_ff <= CORDIC_X0; y_ff <= '0; i_ff <= '0;
               p_ff <= job.travel; turn_ff <= job.turn; sel_ff <= 1'b0;
               st_ff <= S_ROT;
            end
            S_ROT: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - ys_w; y_ff <= y_ff + xs_w;
                  z_ff <= z_ff - 34'(at_w);
               end else begin
                  x_ff <= x_ff + ys_w; y_ff <= y_ff - xs_w;
                  z_ff <= z_ff + 34'(at_w);
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == STEP_W'(NSTEP - 1)) begin
                  st_ff <= S_MUL; ph2_ff <= 2'd0;
               end
            end
            S_MUL: begin
               // magnitude split, partial products, then sum and round
               case (ph2_ff)
                  2'd0: begin
                     mp_ff <= p_ff[47] ? 48'(-p_ff) : p_ff;
                     mc_ff <= c_w[33] ? 32'(-c_w) : c_w[31:0];
                     neg_ff <= p_ff[47] ^ c_w[33];
                     ph2_ff <= 2'd1;
                  end
                  2'd1: begin
                     hi_ff <= 56'(mp_ff[47:24]) * 56'(mc_ff);
                     lo_ff <= 56'(mp_ff[23:0]) * 56'(mc_ff)
                              + 56'h40_0000_0000;
                     ph2_ff <= 2'd2;
                  end
                  default: begin
                     dx_ff <= neg_ff ? -49'(q_w) : 49'(q_w);
                     st_ff <= S_ADD;
                  end
               endcase
            end
            S_ADD: begin
               if (sel_ff) begin
                  py_ff <= sat_w; ph_ff <= ph_ff + turn_ff; st_ff <= S_OUT;
               end else begin
                  px_ff <= sat_w; sel_ff <= 1'b1;
                  ph2_ff <= 2'd0; st_ff <= S_MUL;
               end
            end
            S_OUT: if (!rsp_stall) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_pos))
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      job_take |=> st_ff == S_ROT) else $error("job not started");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == S_ROT |-> i_ff < STEP_W'(NSTEP)) else $error("step overrun");
endmodule
`default_nettype wire

// File: rtl/core/wheel_odometry_pose_update_top.sv
`default_nettype none
// wheel odometry pose tracker
// request channel: req_valid/req_stall with req_wheel_select (0 left, 1 right)
// and signed req_tick_delta; accepted when valid and not stalled.
// result channel: rsp_valid/rsp_stall with the new pose rsp_x_pos, rsp_y_pos
// (2^-24 m, saturating) and rsp_heading (turn * 2^32, wrapping).
// csr port: csr_valid/csr_ready, index 0 dist_per_tick, 1 turn_per_tick;
// write only while idle.
// the front multiplies ticks by the scale registers into a 2-entry queue;
// the back runs one cordic step per cycle for NSTEP steps, then two split
// multiplies (magnitude split, partial products, round) with saturating adds.
// the back takes a new job only from idle, once the last result is accepted.
// a stalled result holds and the back waits; the queue then fills and
// req_stall rises. reset clears the pose and loads the scale defaults.
module wheel_odometry_pose_update_top import wopu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_wheel_select,
   input  wire logic signed [15:0] req_tick_delta,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [47:0] rsp_x_pos,
   output logic signed [47:0] rsp_y_pos,
   output logic [31:0]      rsp_heading,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   logic    job_valid, job_take;
   job_type job;

   wopu_front u_front (.clock, .reset, .req_valid, .req_stall, .req_wheel_select,
      .req_tick_delta, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .job_valid, .job_take, .job);
   wopu_back u_back (.clock, .reset, .job_valid, .job_take, .job,
      .rsp_valid, .rsp_stall, .rsp_x_pos, .rsp_y_pos, .rsp_heading);
endmodule
`default_nettype wire

// File: bench/wheel_odometry_pose_checker.sv
`default_nettype none
module wheel_odometry_pose_checker import wopu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_wheel_select,
   input  wire logic signed [15:0] req_tick_delta,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [47:0] rsp_x_pos,
   input  wire logic signed [47:0] rsp_y_pos,
   input  wire logic [31:0]        rsp_heading,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_data,
   output int                      fail_count,
   output int                      poses_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [47:0] x;
      logic signed [47:0] y;
      logic [31:0]        heading;
   } pose_type;

   localparam logic [31:0] ARCTAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

   longint      track_x, track_y;
   logic [31:0] track_heading;
   logic [31:0] dist_scale, turn_scale;
   pose_type    pose_q[$];

   // round(p * c / 2^39), half away from zero
   function automatic longint scale_travel(input longint p, input longint c);
      logic [127:0] mp, mc, prod;
      longint       q;
      mp = (p < 0) ? -p : p;
      mc = (c < 0) ? -c : c;
      prod = mp * mc + (128'd1 << 38);
      q = longint'(prod[102:39]);
      return ((p < 0) != (c < 0)) ? -q : q;
   endfunction

   function automatic longint clamp48(input longint v);
      if (v > longint'(POS_MAX)) return longint'(POS_MAX);
      if (v < longint'(POS_MIN)) return longint'(POS_MIN);
      return v;
   endfunction

   function automatic pose_type advance_pose(input logic right,
                                             input logic signed [15:0] td);
      longint      t, p, a, cx, cy, z, xs, ys, co, si;
      logic [31:0] half, mid;
      pose_type    r;
      t = td;
      p = t * longint'({32'b0, dist_scale});
      a = t * longint'({32'b0, turn_scale});
      if (!right) a = -a;
      half = 32'(a >>> 1);
      mid = track_heading + half;
      cx = longint'(CORDIC_X0);
      cy = 0;
      z = longint'({34'b0, mid[29:0]});
      for (int i = 0; i < NSTEP; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (z >= 0) begin
            cx = cx - ys; cy = cy + xs; z = z - longint'({32'b0, ARCTAN_TURN[i]});
         end else begin
            cx = cx + ys; cy = cy - xs; z = z + longint'({32'b0, ARCTAN_TURN[i]});
         end
      end
      case (mid[31:30])
         2'd0: begin co = cx; si = cy; end
         2'd1: begin co = -cy; si = cx; end
         2'd2: begin co = -cx; si = -cy; end
         default: begin co = cy; si = -cx; end
      endcase
      track_x = clamp48(track_x + scale_travel(p, co));
      track_y = clamp48(track_y + scale_travel(p, si));
      track_heading = track_heading + a[31:0];
      r.x = track_x[47:0];
      r.y = track_y[47:0];
      r.heading = track_heading;
      return r;
   endfunction

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         track_x = 0;
         track_y = 0;
         track_heading = '0;
         dist_scale = DIST_RESET;
         turn_scale = TURN_RESET;
         pose_q.delete();
         fail_count = 0;
         poses_waiting = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DIST) dist_scale = csr_data;
            else turn_scale = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pose_q.size() == 0) begin
               $error("pose result with no request pending");
               fail_count = fail_count + 1;
            end else begin
               e = pose_q.pop_front();
               if (rsp_x_pos !== e.x) begin
                  $error("x_pos expected %0d actual %0d", e.x, rsp_x_pos);
                  fail_count = fail_count + 1;
               end
               if (rsp_y_pos !== e.y) begin
                  $error("y_pos expected %0d actual %0d", e.y, rsp_y_pos);
                  fail_count = fail_count + 1;
               end
               if (rsp_heading !== e.heading) begin
                  $error("heading expected %08h actual %08h", e.heading, rsp_heading);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            pose_q.push_back(advance_pose(req_wheel_select, req_tick_delta));
         poses_waiting = pose_q.size();
      end
   end
endmodule
`default_nettype wire

// File: bench/wheel_odometry_pose_update_top_tb.sv
`default_nettype none
module wheel_odometry_pose_update_top_tb import wopu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_wheel_select = 0;
   logic signed [15:0] req_tick_delta = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [47:0] rsp_x_pos, rsp_y_pos;
   logic [31:0]        rsp_heading;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic               csr_index = 0;
   logic [31:0]        csr_data = '0;
   int                 fail_count, poses_waiting;
   int                 sent = 0;
   bit                 quiet = 0;

   wheel_odometry_pose_update_top DUT (.*);
   wheel_odometry_pose_checker checker_i (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side backpressure
   initial begin
      int n;
      forever begin
         n = quiet ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_ticks(input logic ws, input logic signed [15:0] td);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_wheel_select <= ws;
      req_tick_delta <= td;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      do @(posedge clock); while (poses_waiting != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic set_scales(input logic [31:0] d, input logic [31:0] t);
      drain();
      write_csr(CSR_DIST, d);
      write_csr(CSR_TURN, t);
   endtask

   task automatic random_ticks(input int n);
      logic signed [15:0] td;
      for (int i = 0; i < n; i++) begin
         td = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 400)) - 200);
         send_ticks(1'($urandom_range(0, 1)), td);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // default, all-ones and zero scales with tick extremes and zero ticks
      send_ticks(0, 16'sd0);
      send_ticks(1, 16'sd0);
      send_ticks(0, 16'sd32767);
      send_ticks(1, 16'sd32767);
      send_ticks(0, -16'sd32768);
      send_ticks(1, -16'sd32768);
      send_ticks(0, 16'sd1);
      send_ticks(1, -16'sd1);
      send_ticks(0, 16'sh5555);
      send_ticks(1, 16'shAAAA);
      set_scales('1, '1);
      send_ticks(1, 16'sd32767);
      send_ticks(0, -16'sd32768);
      send_ticks(1, 16'sd3);
      send_ticks(0, -16'sd7);
      set_scales('0, '0);
      send_ticks(1, 16'sd32767);
      send_ticks(0, -16'sd32768);
      // random scales with random ticks
      set_scales($urandom, $urandom);
      random_ticks(200);
      // stretch with no idling on either side
      quiet = 1;
      set_scales(DIST_RESET, $urandom_range(0, 1 << 20));
      random_ticks(150);
      quiet = 0;
      drain();
      // drive the pose into saturation with zero turn, holding the current heading
      set_scales('1, '0);
      for (int i = 0; i < 560; i++) send_ticks(1'($urandom_range(0, 1)), 16'sd32767);
      // quarter turn, then drive the pose into saturation along the new heading
      set_scales('0, 32'h4000_0000);
      send_ticks(1, 16'sd1);
      set_scales('1, '0);
      for (int i = 0; i < 560; i++) send_ticks(1'($urandom_range(0, 1)), 16'sd32767);
      set_scales($urandom, $urandom);
      random_ticks(150);
      set_scales($urandom_range(0, 1 << 24), $urandom);
      random_ticks(200);
      drain();
      $display("sent %0d tick reports over default, extreme, random and saturating scales",
               sent);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
